### hdl/tma_pkg.sv
package tma_pkg;

	localparam int WORD           = 32;
	localparam int DIM            = 4;
	localparam int MATRIX_ENTRIES = DIM * DIM;
	localparam int FRACTION_BITS  = 16;
	localparam int TW             = WORD + 1;
	localparam int ROW_W          = $clog2(DIM);
	localparam int IDX_W          = $clog2(MATRIX_ENTRIES);

	localparam logic [3:0] OP_IDENTITY  = 4'd0;
	localparam logic [3:0] OP_ZERO      = 4'd1;
	localparam logic [3:0] OP_LOAD_ROW  = 4'd2;
	localparam logic [3:0] OP_MULTIPLY  = 4'd3;
	localparam logic [3:0] OP_TRANSLATE = 4'd4;
	localparam logic [3:0] OP_SCALE     = 4'd5;
	localparam logic [3:0] OP_ROT_X     = 4'd6;
	localparam logic [3:0] OP_ROT_Y     = 4'd7;
	localparam logic [3:0] OP_ROT_Z     = 4'd8;

	typedef logic signed [WORD-1:0] word_t;
	typedef logic signed [TW-1:0]   tval_t;

	typedef struct packed {
		logic [3:0]       opcode;
		logic [ROW_W-1:0] row_select;
		word_t            value_0;
		word_t            value_1;
		word_t            value_2;
		word_t            value_3;
	} cmd_req_t;

	typedef struct packed {
		logic [ROW_W-1:0] row_number;
		word_t            entry_0;
		word_t            entry_1;
		word_t            entry_2;
		word_t            entry_3;
		logic             last_row;
	} row_req_t;

endpackage

### hdl/tma_row_unit.sv
module tma_row_unit #(
	parameter int FRACTION_BITS = tma_pkg::FRACTION_BITS
) (
	input  logic           clk,
	input  logic           en,
	input  tma_pkg::word_t cur_row [tma_pkg::DIM],
	input  tma_pkg::tval_t t       [tma_pkg::MATRIX_ENTRIES],
	output tma_pkg::word_t sum_row [tma_pkg::DIM]
);

	localparam int PW = tma_pkg::WORD + tma_pkg::TW;
	localparam int SW = PW - FRACTION_BITS + 2;

	logic signed [PW-1:0] prod_s2 [tma_pkg::DIM][tma_pkg::DIM];

	// one row of current * T: 16 products per cycle while en is high
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < tma_pkg::DIM; c++) begin
				for (int k = 0; k < tma_pkg::DIM; k++) begin
					prod_s2[c][k] <= PW'($signed(cur_row[k])) * PW'($signed(t[k*tma_pkg::DIM+c]));
				end
			end
		end
	end

	// floor shift, exact sum, saturate
	always_comb begin
		logic signed [SW-1:0] acc;
		for (int c = 0; c < tma_pkg::DIM; c++) begin
			acc = '0;
			for (int k = 0; k < tma_pkg::DIM; k++) begin
				acc = acc + SW'(prod_s2[c][k] >>> FRACTION_BITS);
			end
			if (acc[SW-1:tma_pkg::WORD-1] == '0 || acc[SW-1:tma_pkg::WORD-1] == '1) begin
				sum_row[c] = acc[tma_pkg::WORD-1:0];
			end else if (acc[SW-1]) begin
				sum_row[c] = {1'b1, {(tma_pkg::WORD-1){1'b0}}};
			end else begin
				sum_row[c] = {1'b0, {(tma_pkg::WORD-1){1'b1}}};
			end
		end
	end

endmodule

### hdl/transform_matrix_accumulator_top.sv
// 4x4 transform matrix accumulator, signed fixed point (FRACTION_BITS fraction bits).
// Command channel: cmd_valid / cmd_stall / cmd_request. A command is taken at a rising
// edge with cmd_valid high and cmd_stall low. Result channel: row_valid / row_stall /
// row_request carries the four rows of the current matrix after each command, row 0
// first, last_row set on row 3.
// Row path: command register, row unit product registers, output register. Rows follow
// one per cycle while row_stall is low. The command rate is set by the row unit, which
// forms one result row per cycle while not stalled (16 parallel multipliers, then sum
// and saturate), and by the four rows each command puts on the result channel. The
// next command is taken in the cycle the previous one issues its last row.
// Reset (arst_n low): current matrix becomes identity, operand matrix zero, no result
// pending. A stalled result holds in the output register; the whole pipeline freezes
// behind it and cmd_stall rises once the command register is busy.
module transform_matrix_accumulator_top #(
	parameter int FRACTION_BITS = tma_pkg::FRACTION_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  tma_pkg::cmd_req_t cmd_request,
	output logic              row_valid,
	input  logic              row_stall,
	output tma_pkg::row_req_t row_request
);

	typedef enum logic [1:0] {K_MUL, K_ID, K_ZERO} kind_t;

	localparam int DIM   = tma_pkg::DIM;
	localparam int ROW_W = tma_pkg::ROW_W;
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(DIM - 1);
	localparam tma_pkg::word_t ONE_W = tma_pkg::WORD'(1) << FRACTION_BITS;
	localparam tma_pkg::tval_t ONE_T = tma_pkg::TW'(1) << FRACTION_BITS;

	tma_pkg::word_t    cur_q     [tma_pkg::MATRIX_ENTRIES];
	tma_pkg::word_t    operand_q [tma_pkg::MATRIX_ENTRIES];
	tma_pkg::cmd_req_t cmd_q;
	logic              busy_q;
	logic [ROW_W-1:0]  row_q;
	logic              valid_s2;
	logic [ROW_W-1:0]  row_s2;
	kind_t             kind_s2;
	logic              row_valid_q;
	tma_pkg::row_req_t out_q;

	logic              adv;
	logic              accept;
	kind_t             kind;
	tma_pkg::word_t    cur_row [DIM];
	tma_pkg::tval_t    t       [tma_pkg::MATRIX_ENTRIES];
	tma_pkg::word_t    sum_row [DIM];
	tma_pkg::word_t    new_row [DIM];
	tma_pkg::tval_t    c_t, s_t, ns_t;

	assign adv       = !row_valid_q || !row_stall;
	assign cmd_stall = busy_q && !(adv && row_q == LAST_ROW);
	assign accept    = cmd_valid && !cmd_stall;

	always_comb begin
		for (int k = 0; k < DIM; k++) begin
			cur_row[k] = cur_q[{row_q, ROW_W'(k)}];
		end
	end

	always_comb begin
		case (cmd_q.opcode)
			tma_pkg::OP_IDENTITY: kind = K_ID;
			tma_pkg::OP_ZERO:     kind = K_ZERO;
			default:              kind = K_MUL;
		endcase
	end

	// operand T for the issuing command
	always_comb begin
		c_t  = $signed({cmd_q.value_0[tma_pkg::WORD-1], cmd_q.value_0});
		s_t  = $signed({cmd_q.value_1[tma_pkg::WORD-1], cmd_q.value_1});
		ns_t = -s_t;
		for (int i = 0; i < tma_pkg::MATRIX_ENTRIES; i++) begin
			t[i] = (i / DIM == i % DIM) ? ONE_T : '0;
		end
		case (cmd_q.opcode)
			tma_pkg::OP_MULTIPLY: begin
				for (int i = 0; i < tma_pkg::MATRIX_ENTRIES; i++) begin
					t[i] = $signed({operand_q[i][tma_pkg::WORD-1], operand_q[i]});
				end
			end
			tma_pkg::OP_TRANSLATE: begin
				t[12] = c_t;
				t[13] = s_t;
				t[14] = $signed({cmd_q.value_2[tma_pkg::WORD-1], cmd_q.value_2});
			end
			tma_pkg::OP_SCALE: begin
				t[0]  = c_t;
				t[5]  = s_t;
				t[10] = $signed({cmd_q.value_2[tma_pkg::WORD-1], cmd_q.value_2});
			end
			tma_pkg::OP_ROT_X: begin
				t[5]  = c_t;
				t[6]  = s_t;
				t[9]  = ns_t;
				t[10] = c_t;
			end
			tma_pkg::OP_ROT_Y: begin
				t[0]  = c_t;
				t[2]  = ns_t;
				t[8]  = s_t;
				t[10] = c_t;
			end
			tma_pkg::OP_ROT_Z: begin
				t[0] = c_t;
				t[1] = s_t;
				t[4] = ns_t;
				t[5] = c_t;
			end
			default: ;
		endcase
	end

	tma_row_unit #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_row (
		.clk     (clk),
		.en      (adv),
		.cur_row (cur_row),
		.t       (t),
		.sum_row (sum_row)
	);

	always_comb begin
		for (int c = 0; c < DIM; c++) begin
			case (kind_s2)
				K_ID:    new_row[c] = (row_s2 == ROW_W'(c)) ? ONE_W : '0;
				K_ZERO:  new_row[c] = '0;
				default: new_row[c] = sum_row[c];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			row_q       <= '0;
			valid_s2    <= 1'b0;
			row_valid_q <= 1'b0;
			for (int i = 0; i < tma_pkg::MATRIX_ENTRIES; i++) begin
				cur_q[i]     <= (i / DIM == i % DIM) ? ONE_W : '0;
				operand_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				row_q  <= '0;
			end else if (adv && busy_q) begin
				row_q <= row_q + 1'b1;
				if (row_q == LAST_ROW) begin
					busy_q <= 1'b0;
				end
			end
			if (accept && cmd_request.opcode == tma_pkg::OP_LOAD_ROW) begin
				operand_q[{cmd_request.row_select, ROW_W'(0)}] <= cmd_request.value_0;
				operand_q[{cmd_request.row_select, ROW_W'(1)}] <= cmd_request.value_1;
				operand_q[{cmd_request.row_select, ROW_W'(2)}] <= cmd_request.value_2;
				operand_q[{cmd_request.row_select, ROW_W'(3)}] <= cmd_request.value_3;
			end
			if (adv) begin
				valid_s2    <= busy_q;
				row_valid_q <= valid_s2;
				if (valid_s2) begin
					for (int c = 0; c < DIM; c++) begin
						cur_q[{row_s2, ROW_W'(c)}] <= new_row[c];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_request;
		end
		if (adv && busy_q) begin
			row_s2  <= row_q;
			kind_s2 <= kind;
		end
		if (adv && valid_s2) begin
			out_q.row_number <= row_s2;
			out_q.entry_0    <= new_row[0];
			out_q.entry_1    <= new_row[1];
			out_q.entry_2    <= new_row[2];
			out_q.entry_3    <= new_row[3];
			out_q.last_row   <= (row_s2 == LAST_ROW);
		end
	end

	assign row_valid   = row_valid_q;
	assign row_request = out_q;

endmodule

### hdl/tma_checker.sv
module tma_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input tma_pkg::cmd_req_t cmd_request,
	input logic              row_valid,
	input logic              row_stall,
	input tma_pkg::row_req_t row_request
);

	logic unused_cmd;
	assign unused_cmd = ^cmd_request;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(row_valid && row_stall) |-> row_valid && $stable(row_request))
		else $error("stalled row request changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> (row_request.last_row == (row_request.row_number == 2'd3)))
		else $error("last_row does not match row 3");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(row_valid && !row_stall && !row_request.last_row) |=>
			(!row_valid || row_request.row_number == $past(row_request.row_number) + 2'd1))
		else $error("rows out of order");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command taken while previous still issuing");

	a_reset: assert property (@(posedge clk) !arst_n |=> !row_valid)
		else $error("row valid after reset");

endmodule

bind transform_matrix_accumulator_top tma_checker u_tma_checker (.*);
